// ===== rtl/ple_pkg.sv =====
package ple_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 9;
    localparam int IDX_W        = 9;
    localparam int KIND_W       = 2;
    localparam int STAT_W       = 2;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_LOCATE = 2'd2
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  removed_value;
        logic [IDX_W-1:0]   found_index;
    } result_t;

endpackage

// ===== rtl/ple_ram.sv =====
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ple_ctrl.sv =====
module ple_ctrl
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int ADDR_W  = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [POS_W-1:0]    in_pos,
    input  logic [DATA_W-1:0]   in_value,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output logic [DATA_W-1:0]   ram_wdata,
    output logic                ram_re,
    output logic [ADDR_W-1:0]   ram_raddr,
    input  logic [DATA_W-1:0]   ram_rdata,
    output logic                res_valid,
    input  logic                res_ready,
    output result_t             res
);

    localparam int EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [ADDR_W-1:0]   p0_reg, p0_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [ADDR_W-1:0]   rd_reg, rd_next;
    logic [ADDR_W-1:0]   pa_reg, pa_next;
    logic                pend_reg, pend_next;
    logic                first_reg, first_next;
    logic                hit_reg, hit_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   removed_reg, removed_next;
    logic [IDX_W-1:0]    found_reg, found_next;

    logic [EXT_W-1:0]    pos_eff_ext;
    logic [EXT_W-1:0]    cnt_ext;
    logic [EXT_W-1:0]    p0_ext;
    logic [EXT_W-1:0]    pa_inc_ext;
    logic                match_now;
    logic                issue;

    assign pos_eff_ext = (in_pos == '0) ? EXT_W'(1) : EXT_W'(in_pos);
    assign cnt_ext     = EXT_W'(cnt_reg);
    assign p0_ext      = pos_eff_ext - EXT_W'(1);
    assign pa_inc_ext  = EXT_W'(pa_reg) + EXT_W'(1);

    // Compare the word that came back from the read issued last cycle.
    assign match_now = pend_reg && (kind_reg == KIND_LOCATE) && !hit_reg
                       && (ram_rdata == val_reg);
    assign issue     = (state_reg == ST_RUN) && (rem_reg != '0) && !hit_reg && !match_now;

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign ram_re    = issue;
    assign ram_raddr = rd_reg;

    assign res.status        = status_reg;
    assign res.removed_value = removed_reg;
    assign res.found_index   = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        val_reg     <= val_next;
        p0_reg      <= p0_next;
        rem_reg     <= rem_next;
        rd_reg      <= rd_next;
        pa_reg      <= pa_next;
        first_reg   <= first_next;
        hit_reg     <= hit_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        val_next     = val_reg;
        p0_next      = p0_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        rd_next      = rd_reg;
        pa_next      = pa_reg;
        pend_next    = 1'b0;
        first_next   = first_reg;
        hit_next     = hit_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        found_next   = found_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = ram_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next    = kind_t'(in_kind);
                    val_next     = in_value;
                    p0_next      = p0_ext[ADDR_W-1:0];
                    status_next  = STAT_OK;
                    removed_next = '0;
                    found_next   = '0;
                    first_next   = 1'b1;
                    hit_next     = 1'b0;
                    rem_next     = CNT_W'(cnt_ext - p0_ext);
                    case (kind_t'(in_kind))
                        KIND_INSERT:
                        begin
                            rd_next = ADDR_W'(cnt_ext - EXT_W'(1));
                            if (pos_eff_ext > cnt_ext + EXT_W'(1))
                            begin
                                status_next = STAT_BAD_POS;
                                state_next  = ST_DONE;
                            end
                            else if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        KIND_DELETE:
                        begin
                            rd_next = p0_ext[ADDR_W-1:0];
                            if (pos_eff_ext > cnt_ext)
                            begin
                                status_next = STAT_BAD_POS;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        KIND_LOCATE:
                        begin
                            rd_next    = '0;
                            rem_next   = cnt_reg;
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                // Read one slot a cycle; insert and delete write it back one slot over.
                if (issue)
                begin
                    rem_next  = rem_reg - CNT_W'(1);
                    rd_next   = (kind_reg == KIND_INSERT) ? rd_reg - ADDR_W'(1)
                                                          : rd_reg + ADDR_W'(1);
                    pa_next   = rd_reg;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    case (kind_reg)
                        KIND_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pa_reg + ADDR_W'(1);
                        end
                        KIND_DELETE:
                        begin
                            if (first_reg)
                            begin
                                removed_next = ram_rdata;
                                first_next   = 1'b0;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pa_reg - ADDR_W'(1);
                            end
                        end
                        default:
                        begin
                            if (match_now)
                            begin
                                hit_next   = 1'b1;
                                found_next = pa_inc_ext[IDX_W-1:0];
                            end
                        end
                    endcase
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = p0_reg;
                        ram_wdata = val_reg;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    KIND_DELETE:
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/positional_list_engine.sv =====
// Channel   Direction  Beat contents (lowest bit first)
// s_axis    in         tuser: kind[1:0]; tdata: position[8:0], value[40:9]
// m_axis    out        tdata: status[1:0], removed_value[33:2], found_index[42:34]
//
// One request at a time. Let n be the number of elements moved or compared:
// length - position + 1 for insert and delete, up to length for locate.
// The n elements are handled in RUN, then FINISH and DONE pass before the next is accepted.
// The sequencer walks the element store through its single read port and single
// write port, one element a cycle. Errors and unused kinds go straight to DONE.
// Reset empties the list at once.
// A stalled result is held in the output register; the input stays stalled until it drains.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position, value, zero pad
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, removed_value, found_index, zero pad
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [DATA_W-1:0]  ram_rdata;
    logic               res_valid;
    logic               res_ready;
    result_t            res;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_pos    (s_tdata[POS_W-1:0]),
        .in_value  (s_tdata[POS_W+DATA_W-1:POS_W]),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ple_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({res.found_index, res.removed_value, res.status});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/positional_list_engine_tb.sv =====
module positional_list_engine_tb
    import ple_pkg::*;
();

    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1330;
    localparam int PAD_W        = S_TDATA_W - (POS_W + DATA_W);
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } list_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // position, value, zero pad
    logic [KIND_W-1:0]    s_tuser = '0;   // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // status, removed_value, found_index, zero pad

    // predicted list contents
    logic [DATA_W-1:0] list_store [LIST_CAP];
    int                list_len = 0;

    list_req_t   pending_requests [$];
    result_t     expected_results [$];
    logic [DATA_W-1:0] value_pool [$];

    list_req_t   live_req;
    result_t     live_result;
    result_t     got_result;
    result_t     want_result;
    int          gen_len = 0;
    int          total_requests = 0;
    int          accepted_count = 0;
    int          error_count = 0;
    int          send_gap = 0;
    int          ready_gap = 0;
    int          hold_cycles = 0;
    int          next_hold_at = 200;
    logic        receiver_hold = 1'b0;
    bit          calm_stretch = 1'b0;

    positional_list_engine #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 99) < 3)
            calm_stretch = !calm_stretch;
        r = $urandom_range(0, 99);
        if (calm_stretch || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one request to the predicted list and return the result it must produce.
    task automatic predict_request(input list_req_t req, output result_t res);
        int pos;
        int slot;
        res.status        = STAT_OK;
        res.removed_value = '0;
        res.found_index   = '0;
        pos = (req.position == 0) ? 1 : int'(req.position);
        case (req.kind)
            KIND_INSERT:
            begin
                if (pos > list_len + 1)
                    res.status = STAT_BAD_POS;
                else if (list_len >= LIST_CAP)
                    res.status = STAT_FULL;
                else
                begin
                    for (slot = list_len; slot >= pos; slot--)
                        list_store[slot] = list_store[slot-1];
                    list_store[pos-1] = req.value;
                    list_len++;
                end
            end
            KIND_DELETE:
            begin
                if (pos > list_len)
                    res.status = STAT_BAD_POS;
                else
                begin
                    res.removed_value = list_store[pos-1];
                    for (slot = pos; slot < list_len; slot++)
                        list_store[slot-1] = list_store[slot];
                    list_len--;
                end
            end
            KIND_LOCATE:
            begin
                for (slot = 0; slot < list_len; slot++)
                begin
                    if (list_store[slot] == req.value)
                    begin
                        res.found_index = IDX_W'(slot + 1);
                        break;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Queue a request and track the list length it leaves behind, to steer positions.
    task automatic add_request(input logic [KIND_W-1:0] kind, input int position,
                               input logic [DATA_W-1:0] value);
        list_req_t req;
        int p;
        req.kind     = kind;
        req.position = position[POS_W-1:0];
        req.value    = value;
        pending_requests.push_back(req);
        p = (position == 0) ? 1 : position;
        if (kind == KIND_INSERT && p <= gen_len + 1 && gen_len < LIST_CAP)
        begin
            gen_len++;
            value_pool.push_back(value);
            if (value_pool.size() > 64)
                void'(value_pool.pop_front());
        end
        else if (kind == KIND_DELETE && p <= gen_len)
            gen_len--;
    endtask

    function automatic int pick_position(input logic [KIND_W-1:0] kind);
        int r;
        int top;
        r   = $urandom_range(0, 99);
        top = (kind == KIND_INSERT) ? gen_len + 1 : gen_len;
        if (r < 78)
            return (top == 0) ? 1 : $urandom_range(1, top);
        if (r < 86)
            return 0;
        if (r < 93)
            return (top < 257) ? $urandom_range(top + 1, 257) : 257;
        return (r < 96) ? 256 : 257;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(0, 7);
        if (r < 20)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0;
            endcase
        end
        return $urandom();
    endfunction

    initial
    begin
        int n;
        int r;
        int ins_pct;
        int del_pct;
        logic [KIND_W-1:0] k;
        logic [DATA_W-1:0] v;

        // empty list, then a short list with duplicates and extreme values
        add_request(KIND_LOCATE, 0, 32'h0);
        add_request(KIND_DELETE, 0, 32'h0);
        add_request(KIND_DELETE, 1, 32'h1234_5678);
        add_request(KIND_INSERT, 2, 32'h1111_1111);
        add_request(KIND_INSERT, 0, 32'h7FFF_FFFF);
        add_request(KIND_INSERT, 2, 32'h8000_0000);
        add_request(KIND_INSERT, 1, 32'hFFFF_FFFF);
        add_request(KIND_INSERT, 2, 32'h0);
        add_request(KIND_INSERT, 6, 32'h2222_2222);
        add_request(KIND_INSERT, 257, 32'h3333_3333);
        add_request(KIND_INSERT, 5, 32'h7FFF_FFFF);
        add_request(KIND_LOCATE, 0, 32'h7FFF_FFFF);
        add_request(KIND_LOCATE, 3, 32'h8000_0000);
        add_request(KIND_LOCATE, 1, 32'd12345);
        add_request(KIND_LOCATE, 257, 32'hFFFF_FFFF);
        add_request(KIND_UNUSED, 256, 32'hA5A5_A5A5);
        add_request(KIND_DELETE, 6, 32'h0);
        add_request(KIND_DELETE, 256, 32'h0);
        add_request(KIND_DELETE, 5, 32'h0);
        add_request(KIND_DELETE, 0, 32'h0);
        add_request(KIND_DELETE, 2, 32'h0);
        add_request(KIND_LOCATE, 0, 32'h0);
        add_request(KIND_INSERT, 3, 32'h5555_5555);
        add_request(KIND_INSERT, 1, 32'hAAAA_AAAA);

        // mixed, then grow until full, then shrink, then mixed again
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < 350)
            begin
                ins_pct = 45;
                del_pct = 30;
            end
            else if (n < 750)
            begin
                ins_pct = 85;
                del_pct = 5;
            end
            else if (n < 1100)
            begin
                ins_pct = 10;
                del_pct = 80;
            end
            else
            begin
                ins_pct = 40;
                del_pct = 35;
            end
            r = $urandom_range(0, 99);
            if (r < ins_pct)
                k = KIND_INSERT;
            else if (r < ins_pct + del_pct)
                k = KIND_DELETE;
            else
                k = KIND_LOCATE;
            if (k == KIND_LOCATE)
            begin
                if (value_pool.size() != 0 && $urandom_range(0, 1) == 1)
                    v = value_pool[$urandom_range(0, value_pool.size() - 1)];
                else
                    v = pick_value();
                add_request(k, $urandom_range(0, 257), v);
            end
            else
                add_request(k, pick_position(k), pick_value());
        end
        total_requests = pending_requests.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count != total_requests)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(20 * 3_000_000);
        $display("Some tests failed");
        $finish;
    end

    // request driver: predict on acceptance, then offer the next beat or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_request(live_req, live_result);
                expected_results.push_back(live_result);
                accepted_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    live_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{PAD_W{1'b0}}, live_req.value, live_req.position};
                    s_tuser  <= live_req.kind;
                    send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-offs so the result register fills and input stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiver_hold <= 1'b0;
            hold_cycles = 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            receiver_hold <= (hold_cycles != 0);
        end
        else if (accepted_count >= next_hold_at)
        begin
            hold_cycles = HOLD_CYCLES;
            next_hold_at += 700;
            receiver_hold <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (receiver_hold)
            m_tready <= 1'b0;
        else if (ready_gap > 0)
        begin
            ready_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ((m_tvalid && m_tready) || $urandom_range(0, 19) == 0)
                ready_gap = pick_gap();
        end
    end

    task automatic note_error(input string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result.status        = status_t'(m_tdata[1:0]);
            got_result.removed_value = m_tdata[33:2];
            got_result.found_index   = m_tdata[42:34];
            if (expected_results.size() == 0)
                note_error($sformatf("unexpected result beat: %h", m_tdata));
            else
            begin
                want_result = expected_results.pop_front();
                if (got_result.status != want_result.status)
                    note_error($sformatf("status mismatch: expected %0d, got %0d",
                                         want_result.status, got_result.status));
                if (got_result.removed_value != want_result.removed_value)
                    note_error($sformatf("removed_value mismatch: expected %h, got %h",
                                         want_result.removed_value,
                                         got_result.removed_value));
                if (got_result.found_index != want_result.found_index)
                    note_error($sformatf("found_index mismatch: expected %0d, got %0d",
                                         want_result.found_index, got_result.found_index));
            end
        end
    end

endmodule
